[design/split_trimmed_mean_resistance_macros.svh]
// assertion macros for the split trimmed mean resistance block
// used by the top level, which provides clk_i and rst_ni
`ifndef SPLIT_TRIMMED_MEAN_RESISTANCE_MACROS_SVH
`define SPLIT_TRIMMED_MEAN_RESISTANCE_MACROS_SVH

// same-cycle implication, checked outside reset
`define STMR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define STMR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/stmr_pkg.sv]
// shared types and constants of the split trimmed mean resistance block
// no dependencies
package stmr_pkg;

  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned OUT_W    = 16;
  localparam int unsigned CFG_IW   = 3;
  localparam int unsigned CFG_DW   = 16;

  localparam logic [CFG_IW-1:0] CFG_SPLIT_THRESHOLD = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_TRIM_COUNT      = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_MIN_COUNT       = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_SCALE_Q16       = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_LIMIT_MILLIOHM  = 3'd4;

  localparam logic [OUT_W-1:0] OVER_LIMIT = 16'hFFFF;

  typedef enum logic [8:0] {
    S_LOAD  = 9'b000000001,
    S_FEED  = 9'b000000010,
    S_DRAIN = 9'b000000100,
    S_DIVH  = 9'b000001000,
    S_DIVL  = 9'b000010000,
    S_HIST  = 9'b000100000,
    S_MULT  = 9'b001000000,
    S_DIVR  = 9'b010000000,
    S_EMIT  = 9'b100000000
  } state_e;

  typedef struct packed {
    logic preset;
    logic insert;
    logic drain;
  } sort_ctrl_t;

endpackage

[design/stmr_sort_cell.sv]
// one cell of the insertion sorting chain
// depends on stmr_pkg
module stmr_sort_cell import stmr_pkg::*; (
  input  logic                clk_i,
  input  sort_ctrl_t          ctrl_i,
  input  logic [SAMPLE_W-1:0] x_i,
  input  logic [SAMPLE_W-1:0] left_v_i,
  input  logic                left_lt_i,
  input  logic [SAMPLE_W-1:0] right_v_i,
  output logic [SAMPLE_W-1:0] v_o,
  output logic                lt_o
);

  logic [SAMPLE_W-1:0] v_q;

  assign lt_o = x_i < v_q;
  assign v_o  = v_q;

  // empty cells hold all ones, so they behave as the largest value
  always_ff @(posedge clk_i) begin
    if (ctrl_i.preset) begin
      v_q <= '1;
    end else if (ctrl_i.insert) begin
      if (lt_o) begin
        v_q <= left_lt_i ? left_v_i : x_i;
      end
    end else if (ctrl_i.drain) begin
      v_q <= right_v_i;
    end
  end

endmodule

[design/stmr_div.sv]
// restoring divider, one quotient bit per cycle
// no package dependencies
module stmr_div #(
  parameter int unsigned DVW = 20,
  parameter int unsigned DSW = 9
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [DVW-1:0] dividend_i,
  input  logic [DSW-1:0] divisor_i,
  output logic           done_o,
  output logic [DVW-1:0] quotient_o
);

  localparam int unsigned CW = $clog2(DVW);

  logic [DVW-1:0] quo_q, quo_d;
  logic [DSW-1:0] rem_q, rem_d, dvs_q;
  logic [CW-1:0]  cnt_q;
  logic           busy_q, done_q;
  logic [DSW:0]   trial;
  logic           ge;

  assign trial = {rem_q, quo_q[DVW-1]};
  assign ge    = trial >= {1'b0, dvs_q};

  always_comb begin
    quo_d = {quo_q[DVW-2:0], ge};
    rem_d = ge ? DSW'(trial - {1'b0, dvs_q}) : trial[DSW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(DVW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

[design/split_trimmed_mean_resistance.sv]
// top level of the split trimmed mean resistance block
// depends on stmr_pkg, stmr_sort_cell, stmr_div and the macros header
//
// Samples stream in one per cycle into a ring of WINDOW_DEPTH cells that keeps
// its contents across windows. The transfer marked tlast starts the pass: the
// ring rotates once through an insertion chain of WINDOW_DEPTH sort cells,
// counting the low group on the way, then the chain drains in ascending order
// while the trimmed sums of both groups accumulate. A shared restoring divider
// then forms the two means, the history sum is added up, and the divider forms
// the final scaled average. The pass waits at its end while the previous result
// still waits at the output; a window whose groups are too small ends after the
// rotation with no result. Input is not taken while the pass runs; a finished
// result sits in the output register and does not block the next window.
// Configuration writes are taken at any time but are meant for idle periods.
`include "split_trimmed_mean_resistance_macros.svh"

module split_trimmed_mean_resistance import stmr_pkg::*; #(
  parameter int unsigned WINDOW_DEPTH = 256,
  parameter int unsigned FILTER_DEPTH = 10
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // input samples
  input  logic              s_tvalid_i,
  output logic              s_tready_o,
  input  logic [15:0]       s_tdata_i,   // [11:0] sample, [15:12] zero
  input  logic              s_tlast_i,   // last sample of the window
  // results
  output logic              m_tvalid_o,
  input  logic              m_tready_i,
  output logic [OUT_W-1:0]  m_tdata_o,   // [15:0] resistance_milliohm
  // register writes
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CFG_IW-1:0] cfg_index_i,
  input  logic [CFG_DW-1:0] cfg_data_i
);

  // widths that follow from the parameters
  localparam int unsigned LW  = $clog2(WINDOW_DEPTH) + 1;      // counts up to the depth
  localparam int unsigned SW  = LW + SAMPLE_W;                 // group sums
  localparam int unsigned PW  = $clog2(FILTER_DEPTH + 1);      // history fill count
  localparam int unsigned HIW = (FILTER_DEPTH > 1) ? $clog2(FILTER_DEPTH) : 1;
  localparam int unsigned HSW = SAMPLE_W + PW;                 // history sum
  localparam int unsigned CMW = ((LW > 11) ? LW : 11) + 1;     // size checks

  // configuration registers
  logic [11:0] thr_q;
  logic [5:0]  trim_q;
  logic [10:0] min_q;
  logic [15:0] scale_q;
  logic [15:0] limit_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= 12'd2047;
      trim_q  <= 6'd20;
      min_q   <= 11'd50;
      scale_q <= 16'd5254;
      limit_q <= 16'd300;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SPLIT_THRESHOLD: thr_q   <= cfg_data_i[11:0];
        CFG_TRIM_COUNT:      trim_q  <= cfg_data_i[5:0];
        CFG_MIN_COUNT:       min_q   <= cfg_data_i[10:0];
        CFG_SCALE_Q16:       scale_q <= cfg_data_i;
        CFG_LIMIT_MILLIOHM:  limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // control state
  state_e          state_q, state_d;
  logic [LW-1:0]   wp_q;
  logic [LW-1:0]   cnt_q;
  logic [LW-1:0]   low_cnt_q;
  logic [SW-1:0]   low_sum_q, high_sum_q;
  logic [11:0]     h_mean_q;
  logic            div_go_q;
  logic [HIW-1:0]  hptr_q;
  logic [PW-1:0]   hfill_q;
  logic [PW-1:0]   hidx_q;
  logic [HSW-1:0]  hsum_q;
  logic [HSW+15:0] prod_q;
  logic            out_valid_q;
  logic [OUT_W-1:0] out_q;

  logic s_xfer, last_xfer, cnt_end;
  assign s_tready_o = state_q == S_LOAD;
  assign s_xfer     = s_tvalid_i && s_tready_o;
  assign last_xfer  = s_xfer && s_tlast_i;
  assign cnt_end    = cnt_q == LW'(WINDOW_DEPTH - 1);

  // window ring: written by position while loading, rotated during the feed
  logic [SAMPLE_W-1:0] ring_q [WINDOW_DEPTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
        ring_q[i] <= '0;
      end
    end else if (state_q == S_FEED) begin
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
        ring_q[i] <= ring_q[(i + 1) % WINDOW_DEPTH];
      end
    end else if (s_xfer) begin
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
        if (wp_q == LW'(i)) begin
          ring_q[i] <= s_tdata_i[SAMPLE_W-1:0];
        end
      end
    end
  end

  // insertion sorting chain
  sort_ctrl_t          sctrl;
  logic [SAMPLE_W-1:0] sort_v  [WINDOW_DEPTH];
  logic                sort_lt [WINDOW_DEPTH];

  assign sctrl.preset = last_xfer;
  assign sctrl.insert = state_q == S_FEED;
  assign sctrl.drain  = state_q == S_DRAIN;

  for (genvar g = 0; g < WINDOW_DEPTH; g++) begin : g_cell
    logic [SAMPLE_W-1:0] left_v, right_v;
    logic                left_lt;
    if (g == 0) begin : g_first
      assign left_v  = '0;
      assign left_lt = 1'b0;
    end else begin : g_mid
      assign left_v  = sort_v[g-1];
      assign left_lt = sort_lt[g-1];
    end
    if (g == WINDOW_DEPTH - 1) begin : g_end
      assign right_v = '1;
    end else begin : g_inner
      assign right_v = sort_v[g+1];
    end
    stmr_sort_cell u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (sctrl),
      .x_i       (ring_q[0]),
      .left_v_i  (left_v),
      .left_lt_i (left_lt),
      .right_v_i (right_v),
      .v_o       (sort_v[g]),
      .lt_o      (sort_lt[g])
    );
  end

  // group sizes, size checks and trim bounds in sorted rank
  logic [LW-1:0]  high_cnt, trim_w, lo_end, hi_start, hi_end, kept_l, kept_h;
  logic [CMW-1:0] twice_trim, lc_x, hc_x, min_x;
  logic           groups_ok, in_low, in_high;

  always_comb begin
    high_cnt   = LW'(WINDOW_DEPTH) - low_cnt_q;
    trim_w     = LW'(trim_q);
    twice_trim = CMW'({trim_q, 1'b0});
    lc_x       = CMW'(low_cnt_q);
    hc_x       = CMW'(high_cnt);
    min_x      = CMW'(min_q);
    groups_ok  = (lc_x > min_x) && (lc_x > twice_trim) &&
                 (hc_x > min_x) && (hc_x > twice_trim);
    lo_end     = low_cnt_q - trim_w;
    hi_start   = low_cnt_q + trim_w;
    hi_end     = LW'(WINDOW_DEPTH) - trim_w;
    kept_l     = low_cnt_q - LW'({trim_q, 1'b0});
    kept_h     = high_cnt - LW'({trim_q, 1'b0});
    in_low     = (cnt_q >= trim_w) && (cnt_q < lo_end);
    in_high    = (cnt_q >= hi_start) && (cnt_q < hi_end);
  end

  // shared divider
  logic [SW-1:0] div_dvd;
  logic [LW-1:0] div_dvs;
  logic          div_done;
  logic [SW-1:0] div_quo;

  always_comb begin
    case (state_q)
      S_DIVH: begin
        div_dvd = high_sum_q;
        div_dvs = kept_h;
      end
      S_DIVL: begin
        div_dvd = low_sum_q;
        div_dvs = kept_l;
      end
      default: begin
        // scaled average: floor(sum * scale / 2^16) / fill count
        div_dvd = SW'(prod_q[HSW+15:16]);
        div_dvs = LW'(hfill_q);
      end
    endcase
  end

  stmr_div #(.DVW(SW), .DSW(LW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_go_q),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // difference history, entries only read once filled
  logic [SAMPLE_W-1:0] hist_q [FILTER_DEPTH];
  logic [SAMPLE_W-1:0] diff;
  logic                hist_wr;

  assign diff    = h_mean_q - div_quo[SAMPLE_W-1:0];
  assign hist_wr = (state_q == S_DIVL) && div_done;

  always_ff @(posedge clk_i) begin
    if (hist_wr) begin
      hist_q[hptr_q] <= diff;
    end
  end

  // sequencer
  logic out_free;
  assign out_free = !out_valid_q || m_tready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_LOAD:  if (last_xfer) state_d = S_FEED;
      S_FEED:  if (cnt_end) state_d = S_DRAIN;
      S_DRAIN: begin
        if (!groups_ok) begin
          state_d = S_LOAD;
        end else if (cnt_end) begin
          state_d = S_DIVH;
        end
      end
      S_DIVH:  if (div_done) state_d = S_DIVL;
      S_DIVL:  if (div_done) state_d = S_HIST;
      S_HIST:  if (hidx_q == hfill_q - 1'b1) state_d = S_MULT;
      S_MULT:  state_d = S_DIVR;
      S_DIVR:  if (div_done) state_d = S_EMIT;
      S_EMIT:  if (out_free) state_d = S_LOAD;
      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      wp_q        <= '0;
      cnt_q       <= '0;
      low_cnt_q   <= '0;
      div_go_q    <= 1'b0;
      hptr_q      <= '0;
      hfill_q     <= '0;
      hidx_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      div_go_q <= 1'b0;
      if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_LOAD: begin
          cnt_q     <= '0;
          low_cnt_q <= '0;
          if (last_xfer) begin
            wp_q <= '0;
          end else if (s_xfer && (wp_q < LW'(WINDOW_DEPTH))) begin
            wp_q <= wp_q + 1'b1;
          end
        end
        S_FEED: begin
          cnt_q <= cnt_end ? '0 : cnt_q + 1'b1;
          if (ring_q[0] <= thr_q) begin
            low_cnt_q <= low_cnt_q + 1'b1;
          end
        end
        S_DRAIN: begin
          cnt_q <= cnt_q + 1'b1;
          if (groups_ok && cnt_end) begin
            div_go_q <= 1'b1;
          end
        end
        S_DIVH: begin
          if (div_done) begin
            div_go_q <= 1'b1;
          end
        end
        S_DIVL: begin
          hidx_q <= '0;
          if (div_done) begin
            hptr_q <= (hptr_q == HIW'(FILTER_DEPTH - 1)) ? '0 : hptr_q + 1'b1;
            if (hfill_q < PW'(FILTER_DEPTH)) begin
              hfill_q <= hfill_q + 1'b1;
            end
          end
        end
        S_HIST: begin
          hidx_q <= hidx_q + 1'b1;
        end
        S_MULT: begin
          div_go_q <= 1'b1;
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  logic [SW-1:0] sv0_x;
  assign sv0_x = SW'(sort_v[0]);

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_FEED: begin
        low_sum_q  <= '0;
        high_sum_q <= '0;
      end
      S_DRAIN: begin
        if (in_low) begin
          low_sum_q <= low_sum_q + sv0_x;
        end
        if (in_high) begin
          high_sum_q <= high_sum_q + sv0_x;
        end
      end
      S_DIVH: begin
        if (div_done) begin
          h_mean_q <= div_quo[SAMPLE_W-1:0];
        end
      end
      S_DIVL: begin
        hsum_q <= '0;
      end
      S_HIST: begin
        hsum_q <= hsum_q + HSW'(hist_q[hidx_q[HIW-1:0]]);
      end
      S_MULT: begin
        prod_q <= hsum_q * scale_q;
      end
      S_EMIT: begin
        // quotient holds until the next start, output register only loads when free
        if (out_free) begin
          out_q <= (div_quo >= SW'(limit_q)) ? OVER_LIMIT : div_quo[OUT_W-1:0];
        end
      end
      default: ;
    endcase
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_q;

  // checks
  `STMR_ASSERT_IMP(a_low_count_bounded, state_q == S_FEED, low_cnt_q <= cnt_q,
    "low group count ran ahead of the feed position")
  `STMR_ASSERT_IMP(a_drain_sorted, state_q == S_DRAIN, sort_v[0] <= sort_v[1],
    "sort chain head out of order during drain")
  `STMR_ASSERT_IMP(a_hist_bounds, 1'b1,
    (hfill_q <= PW'(FILTER_DEPTH)) && (hptr_q <= HIW'(FILTER_DEPTH - 1)),
    "history pointer or fill count out of range")
  `STMR_ASSERT_NXT(a_last_starts_feed, last_xfer, state_q == S_FEED,
    "last sample did not start the sort pass")

endmodule

[tb/split_trimmed_mean_resistance_test.sv]
// self-checking bench for split_trimmed_mean_resistance: windows of samples in,
// filtered resistance out, checked against an in-bench trimmed mean predictor
// depends on stmr_pkg and the block's rtl
module split_trimmed_mean_resistance_test;
  import stmr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WIN = 256;
  localparam int unsigned HIST_N = 10;
  localparam int unsigned ITEMS = 1350;
  localparam int unsigned SETTLE = 900;     // one window pass plus slack
  localparam int unsigned STALL_LIMIT = 6000;

  // predictor of the block plus the store of expected resistances
  class resistance_board;
    logic [11:0] store[WIN];
    int unsigned wpos;
    logic [11:0] hist[HIST_N];
    int unsigned hptr, hfill;
    int unsigned thr, trim, min_cnt, scale, limit;
    logic [15:0] expected_q[$];
    int unsigned errors;

    function new();
      foreach (store[i]) store[i] = '0;
      wpos = 0; hptr = 0; hfill = 0;
      thr = 2047; trim = 20; min_cnt = 50; scale = 5254; limit = 300;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
      case (idx)
        CFG_SPLIT_THRESHOLD: thr = val[11:0];
        CFG_TRIM_COUNT:      trim = val[5:0];
        CFG_MIN_COUNT:       min_cnt = val[10:0];
        CFG_SCALE_Q16:       scale = val;
        CFG_LIMIT_MILLIOHM:  limit = val;
        default: ;
      endcase
    endfunction

    // trimmed floor mean of srt[first +: cnt]; 0 when the group is too small
    function automatic bit trimmed_mean(ref logic [11:0] srt[WIN], input int unsigned first,
                                        input int unsigned cnt, output int unsigned mean);
      int unsigned acc;
      acc = 0;
      mean = 0;
      if (cnt <= min_cnt || cnt <= 2 * trim) return 0;
      for (int unsigned i = first + trim; i < first + cnt - trim; i++) acc += srt[i];
      mean = acc / (cnt - 2 * trim);
      return 1;
    endfunction

    // one accepted sample transfer
    function void note_sample(logic [11:0] smp, bit last);
      logic [11:0] srt[WIN];
      logic [11:0] v;
      int j;
      int unsigned low_cnt, hi_m, lo_m;
      longint unsigned acc, res;
      if (wpos < WIN) begin
        store[wpos] = smp;
        wpos++;
      end
      if (!last) return;
      wpos = 0;
      low_cnt = 0;
      foreach (store[i]) begin
        if (store[i] <= thr) low_cnt++;
        srt[i] = store[i];
      end
      for (int i = 1; i < WIN; i++) begin
        v = srt[i];
        j = i;
        while (j > 0 && srt[j-1] > v) begin
          srt[j] = srt[j-1];
          j--;
        end
        srt[j] = v;
      end
      if (!trimmed_mean(srt, low_cnt, WIN - low_cnt, hi_m)) return;
      if (!trimmed_mean(srt, 0, low_cnt, lo_m)) return;
      hist[hptr] = 12'(hi_m - lo_m);
      hptr = (hptr + 1) % HIST_N;
      if (hfill < HIST_N) hfill++;
      acc = 0;
      for (int unsigned i = 0; i < hfill; i++) acc += hist[i];
      res = (acc * scale) / (longint'(hfill) << 16);
      expected_q.push_back(res >= limit ? OVER_LIMIT : 16'(res));
    endfunction

    function void check_result(logic [15:0] got);
      logic [15:0] want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0d", $time, got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got !== want) begin
        $display("%0t: resistance_milliohm mismatch, expected %0d, actual %0d",
                 $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic s_tvalid_i, s_tready_o, s_tlast_i;
  logic [15:0] s_tdata_i;             // [11:0] sample, [15:12] zero
  logic m_tvalid_o, m_tready_i;
  logic [OUT_W-1:0] m_tdata_o;        // [15:0] resistance_milliohm
  logic cfg_valid_i, cfg_ready_o;
  logic [CFG_IW-1:0] cfg_index_i;
  logic [CFG_DW-1:0] cfg_data_i;

  resistance_board board = new();
  int unsigned sent;
  int unsigned idle_cycles;
  bit quiet;                          // stretch with no idling on either side

  split_trimmed_mean_resistance dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // receiver: random stalls at the falling edge, checks at the rising edge
  always @(negedge clk_i) m_tready_i <= quiet || ($urandom_range(0, 99) >= 7);

  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid_o && m_tready_i) board.check_result(m_tdata_o);
  end

  // watchdog on cycles where no transfer happens on any channel
  always @(posedge clk_i) begin
    if ((s_tvalid_i && s_tready_o) || (m_tvalid_o && m_tready_i) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.set_reg(idx, val);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // waits until the block has nothing left to say, then lets a pass finish
  task automatic drain_block();
    while (board.expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic program_regs(int unsigned thr, int unsigned trim, int unsigned mc,
                              int unsigned sc, int unsigned lim);
    drain_block();
    write_reg(CFG_SPLIT_THRESHOLD, CFG_DW'(thr));
    write_reg(CFG_TRIM_COUNT, CFG_DW'(trim));
    write_reg(CFG_MIN_COUNT, CFG_DW'(mc));
    write_reg(CFG_SCALE_Q16, CFG_DW'(sc));
    write_reg(CFG_LIMIT_MILLIOHM, CFG_DW'(lim));
  endtask

  task automatic send_sample(logic [11:0] smp, bit last);
    @(negedge clk_i);
    while (!quiet && $urandom_range(0, 99) < 7) begin
      s_tvalid_i = 1'b0;
      @(negedge clk_i);
    end
    s_tvalid_i = 1'b1;
    s_tdata_i = {4'b0, smp};
    s_tlast_i = last;
    do @(posedge clk_i); while (!s_tready_o);
    board.note_sample(smp, last);
    sent++;
    quiet = (sent >= 500 && sent < 800);
  endtask

  // mostly two clusters split at the threshold, with some extremes and noise
  function automatic logic [11:0] pick_sample();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return 12'd0;
    if (r < 10) return 12'hFFF;
    if (r < 25 || board.thr >= 4095) return 12'($urandom);
    if ($urandom_range(0, 1)) return 12'($urandom_range(0, board.thr));
    return 12'($urandom_range(board.thr + 1, 4095));
  endfunction

  task automatic send_window(int unsigned len);
    for (int unsigned i = 0; i < len; i++) send_sample(pick_sample(), i == len - 1);
    @(negedge clk_i);
    s_tvalid_i = 1'b0;
  endtask

  // short windows mostly, now and then a near-full, full or overlong one to refresh the store
  task automatic random_windows(int unsigned budget);
    int unsigned stop;
    stop = sent + budget;
    while (sent < stop)
      send_window($urandom_range(0, 99) < 7 ? $urandom_range(250, 280) : $urandom_range(1, 24));
  endtask

  initial begin
    rst_ni = 1'b0;
    s_tvalid_i = 1'b0;
    s_tdata_i = '0;
    s_tlast_i = 1'b0;
    m_tready_i = 1'b1;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_SPLIT_THRESHOLD;
    cfg_data_i = '0;
    sent = 0;
    idle_cycles = 0;
    quiet = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: store still all zero, so every sample of the first window sits in the low group
    send_sample(12'd0, 1'b1);
    send_sample(12'hFFF, 1'b0);
    send_sample(12'd2047, 1'b0);
    send_sample(12'd2048, 1'b1);
    @(negedge clk_i);
    s_tvalid_i = 1'b0;
    // no trimming and no minimum: the few samples above the split suffice
    program_regs(2047, 0, 0, 65535, 65534);
    send_sample(12'hFFF, 1'b0);
    send_sample(12'd0, 1'b0);
    send_sample(12'd4000, 1'b1);
    send_sample(12'd1, 1'b1);
    @(negedge clk_i);
    s_tvalid_i = 1'b0;
    // threshold at the top: high group empty
    program_regs(4095, 0, 0, 65535, 65534);
    send_window(5);

    program_regs(2047, 20, 50, 5254, 300);
    send_window(256);
    random_windows(100);
    program_regs(2047, 0, 0, 65535, 65534);
    random_windows(100);
    program_regs(0, 5, 10, 5254, 300);
    random_windows(70);
    program_regs(1500, 63, 100, 30000, 0);
    send_window(300);
    random_windows(100);
    program_regs(2047, 10, 1024, 100, 1000);
    random_windows(40);
    for (int p = 0; p < 3; p++) begin
      program_regs($urandom_range(1000, 3000), $urandom_range(0, 30), $urandom_range(0, 100),
                   $urandom_range(0, 65535), $urandom_range(0, 65534));
      random_windows(80);
    end
    // top up to the planned number of sample transfers
    if (sent < ITEMS) random_windows(ITEMS - sent);

    drain_block();
    if (board.expected_q.size() == 0 && board.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

[split_trimmed_mean_resistance.f]
+incdir+design
design/stmr_pkg.sv
design/stmr_sort_cell.sv
design/stmr_div.sv
design/split_trimmed_mean_resistance.sv
tb/split_trimmed_mean_resistance_test.sv
